### hw/rtl/dirty_rectangle_tracker_defines.svh
// Assertion helpers shared by the tracker RTL.
`ifndef DIRTY_RECTANGLE_TRACKER_DEFINES_SVH
`define DIRTY_RECTANGLE_TRACKER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define DRT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define DRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/drt_pkg.sv
package drt_pkg;

    localparam int RECT_W     = 64;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 15'd128;
    localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 15'd64;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_FINAL = 2'd3
    } cmd_t;

    // Left/top inclusive, right/bottom exclusive.
    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
    } rect_t;

    typedef enum logic [1:0] {
        WR_NEW  = 2'd0,
        WR_GROW = 2'd1,
        WR_CLIP = 2'd2
    } wr_sel_t;

    typedef enum logic [1:0] {
        OUT_QUERY = 2'd0,
        OUT_RECT  = 2'd1,
        OUT_NONE  = 2'd2
    } out_kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ARD,
        ST_ACHK,
        ST_APPEND,
        ST_GRD,
        ST_GDIFF,
        ST_GMUL,
        ST_GCMP,
        ST_BRD,
        ST_BWR,
        ST_QRD,
        ST_QCHK,
        ST_QEMIT,
        ST_FRD,
        ST_FCHK,
        ST_FEND
    } state_t;

    typedef struct packed {
        logic      load_item;
        logic      rd_en;
        logic      wr_en;
        wr_sel_t   wr_sel;
        logic      diff_en;
        logic      mul_en;
        logic      cmp_en;
        logic      cmp_first;
        logic      pend_load;
        logic      out_load;
        out_kind_t out_kind;
        logic      out_hit;
        logic      out_last;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic size_ok;
        logic touch;
        logic strict;
        logic survive;
        logic better;
        logic out_free;
    } dp_sts_t;

    function automatic logic signed [16:0] span(input logic signed [15:0] hi,
                                                input logic signed [15:0] lo);
        span = 17'(hi) - 17'(lo);
    endfunction

endpackage

### hw/rtl/drt_ram.sv
module drt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/drt_datapath.sv
module drt_datapath
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 8,
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             command,
    input  logic signed [15:0]     left,
    input  logic signed [15:0]     top,
    input  logic signed [15:0]     width,
    input  logic signed [15:0]     height,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  dp_cmd_t                ctl,
    input  logic [AW-1:0]          rd_addr,
    input  logic [AW-1:0]          wr_addr,
    output dp_sts_t                sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_DATA_W-1:0]  out_data,
    output logic                   out_none,
    output logic                   out_last
);

    logic [CFG_DATA_W-1:0] screen_width_reg;
    logic [CFG_DATA_W-1:0] screen_height_reg;

    rect_t item_reg;
    logic  size_ok_reg;
    cmd_t  cmd_reg;

    logic [RECT_W-1:0] rd_data;
    rect_t             rd_rect;
    rect_t             grown;
    rect_t             clipped;
    rect_t             wr_rect;
    logic signed [15:0] sw_ext;
    logic signed [15:0] sh_ext;

    logic signed [16:0] dxu_reg, dyu_reg, dxr_reg, dyr_reg;
    logic signed [33:0] pu_reg, pr_reg;
    logic signed [34:0] growth;
    logic signed [34:0] best_growth_reg;

    rect_t pend_reg;
    logic  out_valid_reg;
    logic  out_free;
    logic  out_hit_reg;
    rect_t out_rect_reg;
    logic  out_none_reg;
    logic  out_last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    drt_ram #(
        .WIDTH (RECT_W),
        .DEPTH (MAX_RECTS)
    ) u_store (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (wr_addr),
        .wdata (wr_rect),
        .re    (ctl.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        rd_rect = rect_t'(rd_data);
        sw_ext  = $signed({1'b0, screen_width_reg});
        sh_ext  = $signed({1'b0, screen_height_reg});

        grown.x0 = (item_reg.x0 < rd_rect.x0) ? item_reg.x0 : rd_rect.x0;
        grown.y0 = (item_reg.y0 < rd_rect.y0) ? item_reg.y0 : rd_rect.y0;
        grown.x1 = (item_reg.x1 > rd_rect.x1) ? item_reg.x1 : rd_rect.x1;
        grown.y1 = (item_reg.y1 > rd_rect.y1) ? item_reg.y1 : rd_rect.y1;

        clipped.x0 = (rd_rect.x0 < 16'sd0) ? 16'sd0 : rd_rect.x0;
        clipped.y0 = (rd_rect.y0 < 16'sd0) ? 16'sd0 : rd_rect.y0;
        clipped.x1 = (rd_rect.x1 > sw_ext) ? sw_ext : rd_rect.x1;
        clipped.y1 = (rd_rect.y1 > sh_ext) ? sh_ext : rd_rect.y1;

        case (ctl.wr_sel)
            WR_NEW:  wr_rect = item_reg;
            WR_GROW: wr_rect = grown;
            WR_CLIP: wr_rect = clipped;
            default: wr_rect = item_reg;
        endcase

        growth = 35'(pu_reg) - 35'(pr_reg);
        out_free = !out_valid_reg || out_ready;

        sts.cmd     = cmd_reg;
        sts.size_ok = size_ok_reg;
        sts.touch   = (item_reg.x0 <= rd_rect.x1) && (item_reg.x1 >= rd_rect.x0) &&
                      (item_reg.y0 <= rd_rect.y1) && (item_reg.y1 >= rd_rect.y0);
        sts.strict  = (item_reg.x0 < rd_rect.x1) && (item_reg.x1 > rd_rect.x0) &&
                      (item_reg.y0 < rd_rect.y1) && (item_reg.y1 > rd_rect.y0);
        sts.survive = (clipped.x0 < clipped.x1) && (clipped.y0 < clipped.y1);
        sts.better  = ctl.cmp_first || (growth < best_growth_reg);
        sts.out_free = out_free;
    end

    // Item, growth pipeline and pending-result registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg     <= cmd_t'(command);
            item_reg.x0 <= left;
            item_reg.y0 <= top;
            item_reg.x1 <= left + width;
            item_reg.y1 <= top + height;
            size_ok_reg <= (width > 16'sd0) && (height > 16'sd0);
        end
        if (ctl.diff_en)
        begin
            dxu_reg <= span(grown.x1, grown.x0);
            dyu_reg <= span(grown.y1, grown.y0);
            dxr_reg <= span(rd_rect.x1, rd_rect.x0);
            dyr_reg <= span(rd_rect.y1, rd_rect.y0);
        end
        if (ctl.mul_en)
        begin
            pu_reg <= dxu_reg * dyu_reg;
            pr_reg <= dxr_reg * dyr_reg;
        end
        if (ctl.cmp_en && sts.better)
        begin
            best_growth_reg <= growth;
        end
        if (ctl.pend_load)
        begin
            pend_reg <= clipped;
        end
        if (ctl.out_load)
        begin
            case (ctl.out_kind)
                OUT_QUERY:
                begin
                    out_hit_reg  <= ctl.out_hit;
                    out_rect_reg <= '0;
                    out_none_reg <= 1'b0;
                    out_last_reg <= 1'b1;
                end
                OUT_RECT:
                begin
                    out_hit_reg  <= 1'b0;
                    out_rect_reg <= pend_reg;
                    out_none_reg <= 1'b0;
                    out_last_reg <= ctl.out_last;
                end
                default:
                begin
                    out_hit_reg  <= 1'b0;
                    out_rect_reg <= '0;
                    out_none_reg <= 1'b1;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'd0, out_rect_reg.y1, out_rect_reg.x1,
                        out_rect_reg.y0, out_rect_reg.x0, out_hit_reg};
    assign out_none  = out_none_reg;
    assign out_last  = out_last_reg;

endmodule

### hw/rtl/drt_ctrl.sv
`include "dirty_rectangle_tracker_defines.svh"

module drt_ctrl
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 8,
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dp_sts_t       sts,
    output dp_cmd_t       cmd,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr
);

    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic             hit_reg, hit_next;

    logic [CNT_W-1:0] idx_inc;
    logic             idx_last;
    logic             table_full;
    logic             fin_go;

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_last   = (idx_inc == cnt_reg);
    assign table_full = (cnt_reg == CNT_W'(MAX_RECTS));
    // A surviving entry can only move on once the previous survivor has a free output slot.
    assign fin_go     = !sts.survive || (k_reg == '0) || sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_ADD:
                    begin
                        if (!sts.size_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = ST_APPEND;
                        end
                        else
                        begin
                            state_next = ST_ARD;
                        end
                    end
                    CMD_QUERY: state_next = (cnt_reg == '0) ? ST_QEMIT : ST_QRD;
                    CMD_CLEAR: state_next = ST_IDLE;
                    CMD_FINAL: state_next = (cnt_reg == '0) ? ST_FEND : ST_FRD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_ARD:
            begin
                state_next = ST_ACHK;
            end
            ST_ACHK:
            begin
                if (sts.touch)
                begin
                    state_next = ST_IDLE;
                end
                else if (!idx_last)
                begin
                    state_next = ST_ARD;
                end
                else
                begin
                    state_next = table_full ? ST_GRD : ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                state_next = ST_IDLE;
            end
            ST_GRD:
            begin
                state_next = ST_GDIFF;
            end
            ST_GDIFF:
            begin
                state_next = ST_GMUL;
            end
            ST_GMUL:
            begin
                state_next = ST_GCMP;
            end
            ST_GCMP:
            begin
                state_next = idx_last ? ST_BRD : ST_GRD;
            end
            ST_BRD:
            begin
                state_next = ST_BWR;
            end
            ST_BWR:
            begin
                state_next = ST_IDLE;
            end
            ST_QRD:
            begin
                state_next = ST_QCHK;
            end
            ST_QCHK:
            begin
                state_next = (sts.strict || idx_last) ? ST_QEMIT : ST_QRD;
            end
            ST_QEMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FRD:
            begin
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                if (fin_go)
                begin
                    state_next = idx_last ? ST_FEND : ST_FRD;
                end
            end
            ST_FEND:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        rd_addr   = idx_reg[AW-1:0];
        wr_addr   = idx_reg[AW-1:0];
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        k_next    = k_reg;
        best_next = best_reg;
        hit_next  = hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                idx_next      = '0;
            end
            ST_DISPATCH:
            begin
                hit_next = 1'b0;
                k_next   = '0;
                if (sts.cmd == CMD_CLEAR)
                begin
                    cnt_next = '0;
                end
            end
            ST_ARD, ST_GRD, ST_QRD, ST_FRD:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_ACHK:
            begin
                if (sts.touch)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_GROW;
                end
                else
                begin
                    idx_next = idx_last ? '0 : idx_inc;
                end
            end
            ST_APPEND:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_NEW;
                wr_addr    = cnt_reg[AW-1:0];
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            ST_GDIFF:
            begin
                cmd.diff_en = 1'b1;
            end
            ST_GMUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_GCMP:
            begin
                cmd.cmp_en    = 1'b1;
                cmd.cmp_first = (idx_reg == '0);
                if (sts.better)
                begin
                    best_next = idx_reg;
                end
                idx_next = idx_inc;
            end
            ST_BRD:
            begin
                cmd.rd_en = 1'b1;
                rd_addr   = best_reg[AW-1:0];
            end
            ST_BWR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_GROW;
                wr_addr    = best_reg[AW-1:0];
            end
            ST_QCHK:
            begin
                if (sts.strict)
                begin
                    hit_next = 1'b1;
                end
                idx_next = idx_inc;
            end
            ST_QEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_QUERY;
                    cmd.out_hit  = hit_reg;
                end
            end
            ST_FCHK:
            begin
                wr_addr = k_reg[AW-1:0];
                if (fin_go)
                begin
                    idx_next = idx_inc;
                    if (sts.survive)
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.wr_sel    = WR_CLIP;
                        cmd.pend_load = 1'b1;
                        k_next        = k_reg + CNT_W'(1);
                        if (k_reg != '0)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = OUT_RECT;
                            cmd.out_last = 1'b0;
                        end
                    end
                end
            end
            ST_FEND:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = (k_reg != '0) ? OUT_RECT : OUT_NONE;
                    cmd.out_last = 1'b1;
                    cnt_next     = k_reg;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            best_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            best_reg  <= best_next;
            hit_reg   <= hit_next;
        end
    end

    `DRT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, cnt_reg <= CNT_W'(MAX_RECTS), "table count overflow")
    `DRT_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && in_ready, state_reg == ST_DISPATCH, "accepted beat not dispatched")
    `DRT_ASSERT_IMP(a_compact_order, clk, rst_n, state_reg == ST_FCHK, k_reg <= idx_reg, "compaction write ahead of read")
    `DRT_ASSERT_IMP(a_out_slot_free, clk, rst_n, cmd.out_load, sts.out_free, "result loaded over a waiting beat")

endmodule

### hw/rtl/dirty_rectangle_tracker.sv
// Dirty rectangle tracker.
// Input beats on s_axis carry one command: add a rectangle, query for strict
// overlap, clear the table, or finalize. Add and clear give no output beat; a
// query gives one beat with the hit flag and tlast set; finalize clips every
// stored rectangle to the screen, compacts the table and gives one beat per
// surviving rectangle in table order, tlast on the final one, or a single beat
// with tuser set when nothing survives. The user must write screen size on the
// cfg port only while the block is idle; the block itself does not enforce this.
// One command is processed at a time; tready is high only in the idle state.
// Each table entry is read through the single read port of the table memory
// for a scan, and passes the read, difference, multiply and compare states in
// the least-growth search of a full table. A single output register holds one
// beat; while the receiver stalls, finalize waits for that slot before moving
// on. Reset empties the table and sets the screen to 128 by 64.
module dirty_rectangle_tracker
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // command[1:0], left[17:2], top[33:18], width[49:34], height[65:50]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit[0], out_left[16:1], out_top[32:17], out_right[48:33], out_bottom[64:49]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // none_left[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    logic [1:0]         command;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;

    dp_cmd_t       ctl;
    dp_sts_t       sts;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign command = s_axis_tdata[1:0];
    assign left    = $signed(s_axis_tdata[17:2]);
    assign top     = $signed(s_axis_tdata[33:18]);
    assign width   = $signed(s_axis_tdata[49:34]);
    assign height  = $signed(s_axis_tdata[65:50]);

    drt_ctrl #(
        .MAX_RECTS (MAX_RECTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    drt_datapath #(
        .MAX_RECTS (MAX_RECTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .left      (left),
        .top       (top),
        .width     (width),
        .height    (height),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_none  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
